@@ hw/rtl/radio_sensor_dedup_table_defines.svh @@
// Assertion macros for the sensor dedup table checker.
// No dependencies.
`ifndef RADIO_SENSOR_DEDUP_TABLE_DEFINES_SVH
`define RADIO_SENSOR_DEDUP_TABLE_DEFINES_SVH
// Implication property on clock, disabled in reset.
`define RSD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
// Next-cycle implication property.
`define RSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`endif

@@ hw/rtl/rsd_pkg.sv @@
// Package for the sensor dedup table: widths, codes and cell record types.
// No dependencies.
`default_nettype none
package rsd_pkg;
    localparam int Depth = 16;
    localparam int SlotW = 6;
    localparam int PosW = 4;

    typedef enum logic [2:0] {
        REQ_UPDATE = 3'd0, REQ_SWEEP = 3'd1, REQ_RESET_MM = 3'd2,
        REQ_CLEAR = 3'd3, REQ_READOUT = 3'd4, REQ_RSV5 = 3'd5,
        REQ_RSV6 = 3'd6, REQ_RSV7 = 3'd7
    } t_req;

    typedef enum logic [2:0] {
        ST_NEW = 3'd0, ST_DATA = 3'd1, ST_REPEAT = 3'd2, ST_DROP = 3'd3,
        ST_FULL = 3'd4, ST_DONE = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        FSM_IDLE, FSM_SCAN, FSM_EMIT, FSM_DONE
    } t_fsm;

    typedef struct packed {
        logic        valid;
        logic [19:0] key;
        logic [63:0] code;
        logic [47:0] tstamp;
        logic [23:0] ivl;
        logic [7:0]  sig_cnt;
        logic [7:0]  sig_max;
        logic [2:0]  flags;
        logic [11:0] t_cur;
        logic [11:0] t_min;
        logic [11:0] t_max;
        logic [6:0]  h_cur;
        logic [6:0]  h_min;
        logic [6:0]  h_max;
    } t_entry;

    // Request record held for the whole request and applied at the head cell.
    typedef struct packed {
        t_req        req;
        logic [47:0] tstamp;
        logic [63:0] code;
        logic [15:0] clen;
        logic [7:0]  reps;
        logic [23:0] ivl;
        logic [19:0] key;
        logic [2:0]  flags;
        logic [11:0] temp;
        logic [6:0]  hum;
        logic [3:0]  ttl;
    } t_cmd;

    // Result of processing one entry at the head cell.
    typedef struct packed {
        logic    emit;
        t_status status;
        logic    done;
    } t_res;
endpackage
`default_nettype wire

@@ hw/rtl/radio_sensor_dedup_table.sv @@
// Sixteen-slot sensor table as a rotating ring of cells.
// Each request makes one ring pass, and an update with no match a second pass;
// a result is registered when its slot is at the head cell and the output register is free.
// A new request is taken only while idle; the ring holds while a result waits on an output stall.
// Reset: all slots invalid, ttl_intervals = 2; slot payload undefined until written.
// Depends on rsd_pkg, rsd_cell, rsd_head.
`default_nettype none
module radio_sensor_dedup_table (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_req_type,
    input  wire logic [47:0] i_time_ms,
    input  wire logic [63:0] i_raw_code,
    input  wire logic [15:0] i_code_len_ms,
    input  wire logic [7:0]  i_repeats,
    input  wire logic [23:0] i_interval_ms,
    input  wire logic [19:0] i_sensor_key,
    input  wire logic        i_battery_low,
    input  wire logic [1:0]  i_trend,
    input  wire logic signed [11:0] i_temperature,
    input  wire logic [6:0]  i_humidity,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [3:0]  i_cfg_data,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [5:0]       o_slot_index,
    output logic [2:0]       o_status,
    output logic             o_last,
    output logic [19:0]      o_out_key,
    output logic [7:0]       o_signal_count,
    output logic [2:0]       o_sensor_flags,
    output logic signed [11:0] o_temp_cur,
    output logic signed [11:0] o_temp_min,
    output logic signed [11:0] o_temp_max,
    output logic [6:0]       o_humid_cur,
    output logic [6:0]       o_humid_min,
    output logic [6:0]       o_humid_max
);
    localparam int D = rsd_pkg::Depth;

    rsd_pkg::t_fsm   r_fsm, n_fsm;
    rsd_pkg::t_cmd   r_cmd;
    logic [3:0]      r_ttl;
    logic [rsd_pkg::PosW-1:0] r_pos;     // head slot index during a pass
    logic            r_pass2, r_found, r_taken;
    logic            r_ov;               // output register holds a transfer
    logic            r_ofinal;           // terminating result pending

    rsd_pkg::t_entry w_ent [D];          // cell outputs; slot r_pos at cell 0
    rsd_pkg::t_entry w_head_out;
    rsd_pkg::t_res   w_res;
    logic            w_adv, w_take, w_out_free;

    // The ring rotates: cell k feeds cell k-1; the head writes back into the last cell.
    assign w_out_free = !r_ov || !i_stall;
    assign w_adv = (r_fsm == rsd_pkg::FSM_SCAN) && (!w_res.emit || w_out_free);
    assign w_take = (r_fsm == rsd_pkg::FSM_IDLE) && i_valid;
    assign o_stall = (r_fsm != rsd_pkg::FSM_IDLE);
    assign o_cfg_ready = 1'b1;

    for (genvar k = 0; k < D; k++) begin : g_cell
        rsd_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_shift(w_adv), .i_clear(1'b0),
            .i_entry((k == D - 1) ? w_head_out : w_ent[(k + 1) % D]),
            .o_entry(w_ent[k])
        );
    end

    rsd_head u_head (
        .i_cmd(r_cmd), .i_entry(w_ent[0]), .i_found(r_found),
        .i_last_pass(r_pass2), .i_free_taken(r_taken),
        .o_entry(w_head_out), .o_res(w_res)
    );

    always_comb begin
        n_fsm = r_fsm;
        unique case (r_fsm)
            rsd_pkg::FSM_IDLE: if (i_valid) n_fsm = rsd_pkg::FSM_SCAN;
            rsd_pkg::FSM_SCAN: begin
                if (w_adv && (r_pos == rsd_pkg::PosW'(D - 1))) begin
                    if (r_cmd.req == rsd_pkg::REQ_UPDATE && !r_pass2
                        && !r_found && !(w_res.emit && w_res.done)) begin
                        n_fsm = rsd_pkg::FSM_SCAN;
                    end else begin
                        n_fsm = rsd_pkg::FSM_EMIT;
                    end
                end
            end
            rsd_pkg::FSM_EMIT: if (w_out_free) n_fsm = rsd_pkg::FSM_DONE;
            rsd_pkg::FSM_DONE: if (w_out_free) n_fsm = rsd_pkg::FSM_IDLE;
            default: n_fsm = rsd_pkg::FSM_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm <= rsd_pkg::FSM_IDLE;
            r_ttl <= 4'd2;
            r_ov <= 1'b0;
            r_pos <= '0;
            r_pass2 <= 1'b0;
            r_found <= 1'b0;
            r_taken <= 1'b0;
            r_ofinal <= 1'b0;
        end else begin
            r_fsm <= n_fsm;
            if (i_cfg_valid) r_ttl <= i_cfg_data;
            // A new result loads only when the register is free or emptying.
            if ((w_adv && w_res.emit)
                || (r_fsm == rsd_pkg::FSM_DONE && w_out_free && r_ofinal)) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
            if (w_take) begin
                r_pos <= '0;
                r_pass2 <= 1'b0;
                r_found <= 1'b0;
                r_taken <= 1'b0;
                r_ofinal <= 1'b0;
            end
            if (w_adv) begin
                r_pos <= (r_pos == rsd_pkg::PosW'(D - 1)) ? '0 : r_pos + 1'b1;
                if (r_pos == rsd_pkg::PosW'(D - 1)) r_pass2 <= 1'b1;
                if (w_res.emit && w_res.done) begin
                    if (r_pass2) r_taken <= 1'b1; else r_found <= 1'b1;
                end
            end
            if (r_fsm == rsd_pkg::FSM_EMIT && w_out_free) begin
                // An update already answered skips the terminating result.
                r_ofinal <= !(r_cmd.req == rsd_pkg::REQ_UPDATE && (r_found || r_taken));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd <= '{req: rsd_pkg::t_req'(i_req_type), tstamp: i_time_ms,
                code: i_raw_code, clen: i_code_len_ms, reps: i_repeats,
                ivl: i_interval_ms, key: i_sensor_key,
                flags: {i_battery_low, i_trend}, temp: i_temperature,
                hum: i_humidity, ttl: r_ttl};
        end
        if (w_adv && w_res.emit) begin
            o_slot_index <= rsd_pkg::SlotW'(r_pos);
            o_status <= w_res.status;
            o_last <= w_res.done;
            o_out_key <= w_head_out.key;
            o_signal_count <= w_head_out.sig_cnt;
            o_sensor_flags <= w_head_out.flags;
            o_temp_cur <= w_head_out.t_cur;
            o_temp_min <= w_head_out.t_min;
            o_temp_max <= w_head_out.t_max;
            o_humid_cur <= w_head_out.h_cur;
            o_humid_min <= w_head_out.h_min;
            o_humid_max <= w_head_out.h_max;
        end
        if (r_fsm == rsd_pkg::FSM_DONE && w_out_free && r_ofinal) begin
            o_slot_index <= '0;
            o_status <= (r_cmd.req == rsd_pkg::REQ_UPDATE) ? rsd_pkg::ST_FULL
                                                          : rsd_pkg::ST_DONE;
            o_last <= 1'b1;
            o_out_key <= '0;
            o_signal_count <= '0;
            o_sensor_flags <= '0;
            o_temp_cur <= '0;
            o_temp_min <= '0;
            o_temp_max <= '0;
            o_humid_cur <= '0;
            o_humid_min <= '0;
            o_humid_max <= '0;
        end
    end
    assign o_valid = r_ov;
endmodule
`default_nettype wire

@@ hw/rtl/rsd_cell.sv @@
// One storage cell of the ring; shifts its entry to the next cell on advance.
// Depends on rsd_pkg.
`default_nettype none
module rsd_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_shift,
    input  wire logic           i_clear,
    input  wire rsd_pkg::t_entry i_entry,
    output rsd_pkg::t_entry     o_entry
);
    rsd_pkg::t_entry r_entry;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_entry.valid <= 1'b0;
        end else if (i_shift) begin
            r_entry.valid <= i_entry.valid;
        end
        if (i_shift) begin
            r_entry[$bits(rsd_pkg::t_entry)-2:0] <= i_entry[$bits(rsd_pkg::t_entry)-2:0];
        end
    end
    assign o_entry = r_entry;
endmodule
`default_nettype wire

@@ hw/rtl/rsd_head.sv @@
// Head cell logic: applies the pending request to the entry leaving the ring.
// Depends on rsd_pkg.
`default_nettype none
module rsd_head (
    input  wire rsd_pkg::t_cmd   i_cmd,
    input  wire rsd_pkg::t_entry i_entry,
    input  wire logic       i_found,
    input  wire logic       i_last_pass,
    input  wire logic       i_free_taken,
    output rsd_pkg::t_entry o_entry,
    output rsd_pkg::t_res   o_res
);
    logic signed [49:0] diff;
    logic signed [9:0]  nwin;
    logic signed [27:0] win;
    logic signed [28:0] lim;
    logic hit_code, hit_key;
    logic signed [11:0] tmin, tmax;
    always_comb begin
        o_entry = i_entry;
        o_res = '{emit: 1'b0, status: rsd_pkg::ST_DONE, done: 1'b0};
        diff = $signed({2'b00, i_cmd.tstamp}) - $signed({2'b00, i_entry.tstamp});
        nwin = $signed({2'b00, i_entry.sig_max}) - $signed({2'b00, i_entry.sig_cnt})
             + 10'sd1;
        win = nwin * $signed({1'b0, i_cmd.clen});
        lim = $signed({1'b0, 28'(i_cmd.ttl * i_entry.ivl)});
        hit_code = i_entry.valid && (i_entry.code == i_cmd.code);
        hit_key = i_entry.valid && (i_entry.key == i_cmd.key);
        tmin = ($signed(i_cmd.temp) < $signed(i_entry.t_min)) ? i_cmd.temp : i_entry.t_min;
        tmax = ($signed(i_cmd.temp) > $signed(i_entry.t_max)) ? i_cmd.temp : i_entry.t_max;
        unique case (i_cmd.req)
            rsd_pkg::REQ_UPDATE: begin
                if (!i_found && (hit_code || hit_key)) begin
                    o_res.emit = 1'b1;
                    o_res.done = 1'b1;
                    o_res.status = hit_code ? rsd_pkg::ST_REPEAT : rsd_pkg::ST_DATA;
                    if (diff <= 50'(win)) begin
                        if (i_entry.sig_cnt < i_entry.sig_max) begin
                            o_entry.sig_cnt = i_entry.sig_cnt + 8'd1;
                        end else begin
                            o_res.status = rsd_pkg::ST_DROP;
                        end
                    end else begin
                        o_entry.sig_cnt = 8'd1;
                    end
                    if (o_res.status != rsd_pkg::ST_DROP) begin
                        o_entry.tstamp = i_cmd.tstamp;
                    end
                    if (o_res.status == rsd_pkg::ST_DATA) begin
                        o_entry.code = i_cmd.code;
                        o_entry.flags = i_cmd.flags;
                        o_entry.t_cur = i_cmd.temp;
                        o_entry.t_min = tmin;
                        o_entry.t_max = tmax;
                        o_entry.h_cur = i_cmd.hum;
                        o_entry.h_min = (i_cmd.hum < i_entry.h_min) ? i_cmd.hum : i_entry.h_min;
                        o_entry.h_max = (i_cmd.hum > i_entry.h_max) ? i_cmd.hum : i_entry.h_max;
                    end
                end else if (i_last_pass && !i_found && !i_free_taken && !i_entry.valid) begin
                    o_res.emit = 1'b1;
                    o_res.done = 1'b1;
                    o_res.status = rsd_pkg::ST_NEW;
                    o_entry = '{valid: 1'b1, key: i_cmd.key, code: i_cmd.code,
                        tstamp: i_cmd.tstamp, ivl: i_cmd.ivl, sig_cnt: 8'd1,
                        sig_max: i_cmd.reps, flags: i_cmd.flags, t_cur: i_cmd.temp,
                        t_min: i_cmd.temp, t_max: i_cmd.temp, h_cur: i_cmd.hum,
                        h_min: i_cmd.hum, h_max: i_cmd.hum};
                end
            end
            rsd_pkg::REQ_SWEEP: begin
                if (i_entry.valid && diff > 50'(lim)) begin
                    o_entry.valid = 1'b0;
                end
            end
            rsd_pkg::REQ_RESET_MM: begin
                o_entry.t_min = i_entry.t_cur;
                o_entry.t_max = i_entry.t_cur;
                o_entry.h_min = i_entry.h_cur;
                o_entry.h_max = i_entry.h_cur;
            end
            rsd_pkg::REQ_CLEAR: o_entry.valid = 1'b0;
            rsd_pkg::REQ_READOUT: begin
                o_res.emit = i_entry.valid;
                o_res.status = rsd_pkg::ST_DONE;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

@@ hw/rtl/rsd_checker.sv @@
// Port-level checker for the sensor dedup table, bound to the top level.
// Depends on radio_sensor_dedup_table_defines.svh and rsd_pkg.
`default_nettype none
`include "radio_sensor_dedup_table_defines.svh"
module rsd_port_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_stall,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [2:0] o_status,
    input wire logic       o_last,
    input wire logic [5:0] o_slot_index
);
    `RSD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_status))
    // Readout entries only appear while the request is still in progress.
    `RSD_ASSERT_IMPL(a_part_busy, i_clk, i_rst_n, o_valid && !o_last, o_stall)
    `RSD_ASSERT_IMPL(a_full_last, i_clk, i_rst_n, o_valid && o_status == rsd_pkg::ST_FULL, o_last && o_slot_index == 6'd0)
    `RSD_ASSERT_IMPL(a_upd_last, i_clk, i_rst_n, o_valid && o_status != rsd_pkg::ST_DONE, o_last)
endmodule
bind radio_sensor_dedup_table rsd_port_checker u_rsd_checker (.*);
`default_nettype wire

@@ tb/sv/rsd_checker.sv @@
// Predictor and result checker for the sensor dedup table.
// Depends on rsd_pkg; instantiated by tb_radio_sensor_dedup_table.
`timescale 1ns / 100ps
module rsd_checker
    import rsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  logic [2:0]  i_req_type,
    input  logic [47:0] i_time_ms,
    input  logic [63:0] i_raw_code,
    input  logic [15:0] i_code_len_ms,
    input  logic [7:0]  i_repeats,
    input  logic [23:0] i_interval_ms,
    input  logic [19:0] i_sensor_key,
    input  logic        i_battery_low,
    input  logic [1:0]  i_trend,
    input  logic [11:0] i_temperature,
    input  logic [6:0]  i_humidity,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [3:0]  i_cfg_data,
    input  logic        o_valid,
    input  logic        i_stall_out,
    input  logic [5:0]  o_slot_index,
    input  logic [2:0]  o_status,
    input  logic        o_last,
    input  logic [19:0] o_out_key,
    input  logic [7:0]  o_signal_count,
    input  logic [2:0]  o_sensor_flags,
    input  logic [11:0] o_temp_cur,
    input  logic [11:0] o_temp_min,
    input  logic [11:0] o_temp_max,
    input  logic [6:0]  o_humid_cur,
    input  logic [6:0]  o_humid_min,
    input  logic [6:0]  o_humid_max,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count
);
    typedef struct packed {
        logic [5:0]  slot;
        logic [2:0]  status;
        logic        last;
        logic [19:0] key;
        logic [7:0]  cnt;
        logic [2:0]  flags;
        logic [11:0] tc, tmn, tmx;
        logic [6:0]  hc, hmn, hmx;
    } t_report;

    t_entry  table_q[Depth];
    logic [3:0] ttl_q;
    t_report reports_q[$];

    assign o_pending = reports_q.size();

    function automatic t_report entry_report(int s, t_status st);
        t_report r;
        r = '0;
        r.status = st;
        if (s >= 0) begin
            r.slot = s[5:0];
            r.key = table_q[s].key;
            r.cnt = table_q[s].sig_cnt;
            r.flags = table_q[s].flags;
            r.tc = table_q[s].t_cur;
            r.tmn = table_q[s].t_min;
            r.tmx = table_q[s].t_max;
            r.hc = table_q[s].h_cur;
            r.hmn = table_q[s].h_min;
            r.hmx = table_q[s].h_max;
        end
        return r;
    endfunction

    task automatic push_report(int s, t_status st, logic lst);
        t_report r;
        r = entry_report(s, st);
        r.last = lst;
        reports_q.push_back(r);
    endtask

    task automatic apply_update();
        int hit;
        int s;
        t_status st;
        longint diff, win;
        hit = -1;
        st = ST_NEW;
        for (s = 0; s < Depth; s++) begin
            if (table_q[s].valid) begin
                if (table_q[s].code == i_raw_code) begin
                    st = ST_REPEAT; hit = s; break;
                end
                if (table_q[s].key == i_sensor_key) begin
                    st = ST_DATA; hit = s; break;
                end
            end
        end
        if (hit >= 0) begin
            diff = longint'({16'd0, i_time_ms}) - longint'({16'd0, table_q[hit].tstamp});
            win = (longint'(table_q[hit].sig_max) - longint'(table_q[hit].sig_cnt) + 1)
                  * longint'(i_code_len_ms);
            if (diff <= win) begin
                if (table_q[hit].sig_cnt < table_q[hit].sig_max) begin
                    table_q[hit].sig_cnt++;
                end else begin
                    push_report(hit, ST_DROP, 1'b1);
                    return;
                end
            end else begin
                table_q[hit].sig_cnt = 8'd1;
            end
            s = hit;
        end else begin
            for (s = 0; s < Depth; s++) if (!table_q[s].valid) break;
            if (s >= Depth) begin
                push_report(-1, ST_FULL, 1'b1);
                return;
            end
            table_q[s].valid = 1'b1;
            table_q[s].ivl = i_interval_ms;
            table_q[s].key = i_sensor_key;
            table_q[s].sig_cnt = 8'd1;
            table_q[s].sig_max = i_repeats;
            table_q[s].t_min = i_temperature;
            table_q[s].t_max = i_temperature;
            table_q[s].h_min = i_humidity;
            table_q[s].h_max = i_humidity;
        end
        table_q[s].tstamp = i_time_ms;
        if (st != ST_REPEAT) begin
            if ($signed(i_temperature) < $signed(table_q[s].t_min))
                table_q[s].t_min = i_temperature;
            if ($signed(i_temperature) > $signed(table_q[s].t_max))
                table_q[s].t_max = i_temperature;
            if (i_humidity < table_q[s].h_min) table_q[s].h_min = i_humidity;
            if (i_humidity > table_q[s].h_max) table_q[s].h_max = i_humidity;
            table_q[s].t_cur = i_temperature;
            table_q[s].h_cur = i_humidity;
            table_q[s].code = i_raw_code;
            table_q[s].flags = {i_battery_low, i_trend};
        end
        push_report(s, st, 1'b1);
    endtask

    task automatic apply_request();
        longint diff, lim;
        int s;
        case (t_req'(i_req_type))
            REQ_UPDATE: begin
                apply_update();
                return;
            end
            REQ_SWEEP: begin
                for (s = 0; s < Depth; s++) begin
                    if (table_q[s].valid) begin
                        diff = longint'({16'd0, i_time_ms})
                               - longint'({16'd0, table_q[s].tstamp});
                        lim = longint'(ttl_q) * longint'(table_q[s].ivl);
                        if (diff > lim) table_q[s].valid = 1'b0;
                    end
                end
            end
            REQ_RESET_MM: begin
                for (s = 0; s < Depth; s++) begin
                    if (table_q[s].valid) begin
                        table_q[s].t_min = table_q[s].t_cur;
                        table_q[s].t_max = table_q[s].t_cur;
                        table_q[s].h_min = table_q[s].h_cur;
                        table_q[s].h_max = table_q[s].h_cur;
                    end
                end
            end
            REQ_CLEAR: for (s = 0; s < Depth; s++) table_q[s].valid = 1'b0;
            REQ_READOUT: begin
                for (s = 0; s < Depth; s++)
                    if (table_q[s].valid) push_report(s, ST_DONE, 1'b0);
            end
            default: ;
        endcase
        push_report(-1, ST_DONE, 1'b1);
    endtask

    always @(posedge i_clk) begin
        t_report got, want;
        if (!i_rst_n) begin
            ttl_q <= 4'd2;
            for (int s = 0; s < Depth; s++) table_q[s] = '0;
            reports_q.delete();
            o_fail_count <= 0;
            o_result_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) ttl_q <= i_cfg_data;
            if (o_valid && !i_stall_out) begin
                got = {o_slot_index, o_status, o_last, o_out_key, o_signal_count,
                       o_sensor_flags, o_temp_cur, o_temp_min, o_temp_max,
                       o_humid_cur, o_humid_min, o_humid_max};
                o_result_count <= o_result_count + 1;
                if (reports_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = reports_q.pop_front();
                    if (got != want) begin
                        $display("%0t: mismatch expected %h actual %h", $time, want, got);
                        $display("  slot %0d/%0d status %0d/%0d last %0d/%0d key %h/%h",
                                 want.slot, got.slot, want.status, got.status,
                                 want.last, got.last, want.key, got.key);
                        $display("  cnt %0d/%0d flags %0d/%0d t %h %h %h / %h %h %h",
                                 want.cnt, got.cnt, want.flags, got.flags, want.tc,
                                 want.tmn, want.tmx, got.tc, got.tmn, got.tmx);
                        $display("  h %0d %0d %0d / %0d %0d %0d", want.hc, want.hmn,
                                 want.hmx, got.hc, got.hmn, got.hmx);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            // request predicted after the output pop so a result is never
            // compared against its own transfer cycle
            if (i_valid && !i_stall_in) apply_request();
        end
    end
endmodule

@@ tb/sv/tb_radio_sensor_dedup_table.sv @@
// Top-level testbench for radio_sensor_dedup_table: clock, reset, stimulus, verdict.
// Depends on rsd_pkg, the block, and rsd_checker (which predicts and compares).
`timescale 1ns / 100ps
module tb_radio_sensor_dedup_table;
    import rsd_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_req_type;
    logic [47:0] i_time_ms;
    logic [63:0] i_raw_code;
    logic [15:0] i_code_len_ms;
    logic [7:0]  i_repeats;
    logic [23:0] i_interval_ms;
    logic [19:0] i_sensor_key;
    logic        i_battery_low;
    logic [1:0]  i_trend;
    logic [11:0] i_temperature;
    logic [6:0]  i_humidity;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_data;
    logic        o_valid;
    logic        i_stall;
    logic [5:0]  o_slot_index;
    logic [2:0]  o_status;
    logic        o_last;
    logic [19:0] o_out_key;
    logic [7:0]  o_signal_count;
    logic [2:0]  o_sensor_flags;
    logic [11:0] o_temp_cur, o_temp_min, o_temp_max;
    logic [6:0]  o_humid_cur, o_humid_min, o_humid_max;
    int          fail_count;
    int          pending;
    int          result_count;

    // quiet: no idling on either side in the last part of the run
    bit          quiet;
    int          item_count;

    // a small pool of sensors so updates hit, repeat and fill the table
    logic [19:0] key_pool[24];
    logic [63:0] code_pool[24];
    logic [47:0] clock_ms;

    radio_sensor_dedup_table dut (.*);

    rsd_checker checker_i (
        .i_clk, .i_rst_n, .i_valid, .i_stall_in(o_stall), .i_req_type, .i_time_ms,
        .i_raw_code, .i_code_len_ms, .i_repeats, .i_interval_ms, .i_sensor_key,
        .i_battery_low, .i_trend, .i_temperature, .i_humidity,
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_data,
        .o_valid, .i_stall_out(i_stall), .o_slot_index, .o_status, .o_last,
        .o_out_key, .o_signal_count, .o_sensor_flags, .o_temp_cur, .o_temp_min,
        .o_temp_max, .o_humid_cur, .o_humid_min, .o_humid_max,
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Watchdog: fails the run if it has not finished by the time-out.
    initial begin
        #2000000;
        $display("timeout with %0d results outstanding", pending);
        $display("FAILED: results differ");
        $finish;
    end

    // Receiver: random stall bursts, separated by free runs.
    initial begin
        int n;
        i_stall = 1'b0;
        forever begin
            n = $urandom_range(1, 30);
            repeat (n) @(posedge i_clk);
            if (!quiet && $urandom_range(0, 1)) begin
                i_stall <= 1'b1;
                n = $urandom_range(1, 17);
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // One request transfer; fields given directly.
    task automatic send_item(t_req rq, logic [47:0] t, logic [63:0] code,
                             logic [15:0] clen, logic [7:0] reps, logic [23:0] ivl,
                             logic [19:0] key, logic [2:0] flags, logic [11:0] temp,
                             logic [6:0] hum);
        int n;
        // sender gap before the transfer
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            n = $urandom_range(1, 17);
            repeat (n) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_req_type    <= rq;
        i_time_ms     <= t;
        i_raw_code    <= code;
        i_code_len_ms <= clen;
        i_repeats     <= reps;
        i_interval_ms <= ivl;
        i_sensor_key  <= key;
        i_battery_low <= flags[2];
        i_trend       <= flags[1:0];
        i_temperature <= temp;
        i_humidity    <= hum;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        item_count++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        // the block may still be finishing its ring passes after the last result
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_ttl(logic [3:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Random update built around the sensor pool: mostly repeats and fresh data
    // close in time, sometimes unrelated codes and keys.
    task automatic random_update();
        int p;
        logic [63:0] code;
        logic [19:0] key;
        logic [15:0] clen;
        p = $urandom_range(0, 23);
        clen = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(1, 200));
        case ($urandom_range(0, 5))
            0, 1: begin
                code = code_pool[p]; key = key_pool[p];          // repeat
            end
            2, 3: begin
                code = {$urandom, $urandom}; key = key_pool[p];  // new data
                code_pool[p] = code;
            end
            4: begin
                code = {$urandom, $urandom}; key = 20'($urandom);
            end
            default: begin
                code = code_pool[p]; key = 20'($urandom);        // code match, other key
            end
        endcase
        case ($urandom_range(0, 3))
            0: clock_ms = clock_ms - 48'($urandom_range(0, 500));  // older message
            1: clock_ms = clock_ms + 48'($urandom_range(0, 100));
            2: clock_ms = clock_ms + 48'($urandom_range(0, 5000));
            default: clock_ms = clock_ms + 48'($urandom);
        endcase
        send_item(REQ_UPDATE, clock_ms, code, clen, 8'($urandom_range(0, 6)),
                  24'($urandom_range(0, 3)) == 0 ? 24'($urandom) : 24'($urandom_range(1, 5000)),
                  key, 3'($urandom), 12'($urandom),
                  $urandom_range(0, 7) == 0 ? 7'($urandom) : 7'($urandom_range(0, 100)));
    endtask

    initial begin
        logic [63:0] ones;
        int sel;
        ones = '1;
        quiet = 1'b0;
        item_count = 0;
        clock_ms = 48'd1000000;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req_type = REQ_UPDATE;
        i_time_ms = '0;
        i_raw_code = '0;
        i_code_len_ms = '0;
        i_repeats = '0;
        i_interval_ms = '0;
        i_sensor_key = '0;
        i_battery_low = 1'b0;
        i_trend = '0;
        i_temperature = '0;
        i_humidity = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        for (int k = 0; k < 24; k++) begin
            key_pool[k] = 20'($urandom);
            code_pool[k] = {$urandom, $urandom};
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, each request, window and drop behavior.
        send_item(REQ_READOUT, 0, 0, 0, 0, 0, 0, 0, 0, 0);           // empty table
        send_item(REQ_UPDATE, 0, 0, 0, 0, 0, 0, 0, 12'h800, 0);    // sig_max 0
        send_item(REQ_UPDATE, 0, 0, 0, 0, 0, 0, 0, 0, 0);          // zero window, drop
        send_item(REQ_UPDATE, '1, ones, '1, '1, '1, '1, 3'h7, 12'h7FF, 7'h7F);
        send_item(REQ_UPDATE, 48'hFFFF_FFFF_FFF0, ones, '1, 0, 0, 20'h1, 0, 12'h000, 7'd100);
        send_item(REQ_UPDATE, 100, 64'h55, 10, 2, 1000, 20'hABCDE, 3'h3, 12'hF00, 40);
        send_item(REQ_UPDATE, 105, 64'h55, 10, 2, 1000, 20'hABCDE, 3'h3, 12'hF00, 40);
        send_item(REQ_UPDATE, 110, 64'h55, 10, 2, 1000, 20'hABCDE, 3'h3, 12'hF00, 40);
        send_item(REQ_UPDATE, 90, 64'h56, 10, 2, 1000, 20'hABCDE, 3'h4, 12'h100, 90);
        send_item(REQ_UPDATE, 5000, 64'h57, 10, 2, 1000, 20'hABCDE, 3'h2, 12'h010, 5);
        send_item(REQ_READOUT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(REQ_RESET_MM, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(REQ_READOUT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(REQ_SWEEP, 5100, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(REQ_SWEEP, 7001, 0, 0, 0, 0, 0, 0, 0, 0);
        for (int k = 0; k < 17; k++)                               // fill, then full
            send_item(REQ_UPDATE, 10, 64'(k + 1000), 5, 1, 100, 20'(k + 7000), 0, 12'(k), 7'(k));
        send_item(REQ_RSV5, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(REQ_RSV7, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(REQ_READOUT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        // sender holds off until every expected result is back
        drain();
        write_ttl(4'd0);
        send_item(REQ_UPDATE, 50, 64'h99, 5, 3, 20, 20'h12345, 0, 0, 0);
        send_item(REQ_SWEEP, 51, 0, 0, 0, 0, 0, 0, 0, 0);
        write_ttl(4'd15);

        // Random phases, each with its own ttl setting.
        for (int ph = 0; ph < 4; ph++) begin
            if (ph == 3) quiet = 1'b1;
            for (int k = 0; k < 85; k++) begin
                sel = $urandom_range(0, 99);
                if (sel < 80) random_update();
                else if (sel < 88)
                    send_item(REQ_SWEEP, clock_ms + 48'($urandom_range(0, 20000)),
                              {$urandom, $urandom}, 16'($urandom), 8'($urandom),
                              24'($urandom), 20'($urandom), 3'($urandom), 12'($urandom),
                              7'($urandom));
                else if (sel < 92)
                    send_item(REQ_READOUT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
                else if (sel < 95)
                    send_item(REQ_RESET_MM, 0, 0, 0, 0, 0, 0, 0, 0, 0);
                else if (sel < 97)
                    send_item(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
                else
                    send_item(t_req'($urandom_range(5, 7)), 48'($urandom), 0, 0, 0, 0,
                              0, 0, 0, 0);
            end
            if (ph < 3) write_ttl(ph == 0 ? 4'd1 : 4'($urandom_range(2, 14)));
        end
        drain();

        $display("Covered %0d requests (updates, sweeps, readouts, resets, clears), %0d results",
                 item_count, result_count);
        $display("ttl settings 0, 1, 15 and random; stalls and gaps on both channels");
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
